/* hdl/imu_sfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Types, frame codes and the fixed-point scaling functions shared by the
// frame assembler, the result scaler and the top level.
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // Bytes per frame; the count of bytes held runs from 0 to FRAME_LEN - 1.
  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned CNT_W     = 4;
  // Held bytes that are ever read: the type byte and three data words.
  localparam int unsigned HELD_USED = 7;
  localparam int unsigned HELD_IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_OTHER = 2'd3
  } frame_kind_t;

  typedef logic [2:0][15:0] word3_t;

  // Handoff from the assembler to the scaler: one completed frame.
  typedef struct packed {
    logic        valid;
    frame_kind_t kind;
  } frame_ctl_t;

  // floor(raw * 125 / 128): deg/s with 4 fraction bits.
  function automatic logic [15:0] gyro_scale(input logic [15:0] raw);
    logic signed [22:0] prod;
    prod = 23'($signed(raw)) * 23'sd125;
    return prod[22:7];
  endfunction

  // floor(raw * 45 / 64): degrees with 7 fraction bits.
  function automatic logic [15:0] angle_scale(input logic [15:0] raw);
    logic signed [21:0] prod;
    prod = 22'($signed(raw)) * 22'sd45;
    return prod[21:6];
  endfunction

endpackage
`default_nettype wire

/* hdl/imu_sfp_assembler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame assembler
// Counts bytes into 11-byte frames, holds the type and data bytes, and loads
// the accel, gyro or angle words when the last byte of a frame arrives.
// ----------------------------------------------------------------------------
module imu_sfp_assembler import imu_sfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_take,
  input  wire logic [7:0] byte_data,
  input  wire logic       ctl_take,
  output frame_ctl_t      ctl,
  output word3_t          accel,
  output word3_t          gyro,
  output word3_t          angle
);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       frame_bytes_r [HELD_USED];
  frame_ctl_t       ctl_r, ctl_nxt;
  word3_t           accel_r, accel_nxt;
  word3_t           gyro_r, gyro_nxt;
  word3_t           angle_r, angle_nxt;
  word3_t           words;
  logic [CNT_W-1:0] held_pos;
  logic             last_byte;

  assign held_pos  = byte_count_r - CNT_W'(1);
  assign last_byte = byte_count_r == CNT_W'(FRAME_LEN - 1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      words[i] = {frame_bytes_r[2 + 2 * i], frame_bytes_r[1 + 2 * i]};
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    ctl_nxt        = ctl_r;
    accel_nxt      = accel_r;
    gyro_nxt       = gyro_r;
    angle_nxt      = angle_r;
    if (ctl_take) begin
      ctl_nxt.valid = 1'b0;
    end
    if (byte_take) begin
      if (byte_count_r == '0) begin
        if (byte_data == START_BYTE) begin
          byte_count_nxt = CNT_W'(1);
        end
      end else if (!last_byte) begin
        byte_count_nxt = byte_count_r + CNT_W'(1);
      end else begin
        byte_count_nxt = '0;
        ctl_nxt.valid  = 1'b1;
        case (frame_bytes_r[0])
          TYPE_ACCEL: begin
            accel_nxt    = words;
            ctl_nxt.kind = KIND_ACCEL;
          end
          TYPE_GYRO: begin
            gyro_nxt     = words;
            ctl_nxt.kind = KIND_GYRO;
          end
          TYPE_ANGLE: begin
            angle_nxt    = words;
            ctl_nxt.kind = KIND_ANGLE;
          end
          default: begin
            ctl_nxt.kind = KIND_OTHER;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      ctl_r        <= '{valid: 1'b0, kind: KIND_OTHER};
      accel_r      <= '0;
      gyro_r       <= '0;
      angle_r      <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      ctl_r        <= ctl_nxt;
      accel_r      <= accel_nxt;
      gyro_r       <= gyro_nxt;
      angle_r      <= angle_nxt;
    end
  end

  // Only the type byte and the three data words are kept; the fourth word
  // and the checksum are never read.
  always_ff @(posedge clk) begin
    if (byte_take && byte_count_r != '0 && !last_byte &&
        held_pos < CNT_W'(HELD_USED)) begin
      frame_bytes_r[held_pos[HELD_IDX_W-1:0]] <= byte_data;
    end
  end

  assign ctl   = ctl_r;
  assign accel = accel_r;
  assign gyro  = gyro_r;
  assign angle = angle_r;

endmodule
`default_nettype wire

/* hdl/imu_sfp_scaler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU result scaler
// Scales the stored gyro and angle words to fixed point and holds the full
// nine-value result in the output register until it is taken.
// ----------------------------------------------------------------------------
module imu_sfp_scaler import imu_sfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire frame_ctl_t ctl,
  input  wire word3_t     accel,
  input  wire word3_t     gyro,
  input  wire word3_t     angle,
  output logic            ctl_take,
  input  wire logic       res_ready,
  output logic            res_valid,
  output frame_kind_t     res_kind,
  output word3_t          res_accel,
  output word3_t          res_rate,
  output word3_t          res_angle
);

  logic        valid_r;
  frame_kind_t kind_r;
  word3_t      accel_r, rate_r, angle_r;
  word3_t      rate_nxt, angle_nxt;
  logic        load;

  assign load     = !valid_r || res_ready;
  assign ctl_take = load && ctl.valid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rate_nxt[i]  = gyro_scale(gyro[i]);
      angle_nxt[i] = angle_scale(angle[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_take) begin
      kind_r  <= ctl.kind;
      accel_r <= accel;
      rate_r  <= rate_nxt;
      angle_r <= angle_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res_kind  = kind_r;
  assign res_accel = accel_r;
  assign res_rate  = rate_r;
  assign res_angle = angle_r;

endmodule
`default_nettype wire

/* hdl/imu_serial_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// A completed frame's result is valid once its last byte has passed the
// assembler register, then the scaling output register. Throughput: one byte
// per cycle unless a finished frame is blocked behind a held result; the
// output and frame registers let the next byte in while a result waits.
// Reset: synchronous, active low; clears the byte count, the three stores and
// both valid flags. Held frame bytes are not reset.
// ----------------------------------------------------------------------------
// IMU serial frame parser
// Assembles 11-byte sensor frames from serial bytes and reports the raw accel
// and the scaled rate and angle values after every completed frame.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser import imu_sfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_frame_kind,
  output logic [15:0]      out_accel_x,
  output logic [15:0]      out_accel_y,
  output logic [15:0]      out_accel_z,
  output logic [15:0]      out_rate_x,
  output logic [15:0]      out_rate_y,
  output logic [15:0]      out_rate_z,
  output logic [15:0]      out_roll_deg,
  output logic [15:0]      out_pitch_deg,
  output logic [15:0]      out_yaw_deg
);

  frame_ctl_t  ctl;
  logic        ctl_take;
  logic        in_take;
  word3_t      accel, gyro, angle;
  frame_kind_t res_kind;
  word3_t      res_accel, res_rate, res_angle;

  // A byte may complete a frame, so the frame register must be free or
  // draining into the output register this cycle.
  assign in_ready = !ctl.valid || ctl_take;
  assign in_take  = in_valid && in_ready;

  imu_sfp_assembler u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (in_take),
    .byte_data (in_byte_in),
    .ctl_take  (ctl_take),
    .ctl       (ctl),
    .accel     (accel),
    .gyro      (gyro),
    .angle     (angle)
  );

  imu_sfp_scaler u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .accel     (accel),
    .gyro      (gyro),
    .angle     (angle),
    .ctl_take  (ctl_take),
    .res_ready (out_ready),
    .res_valid (out_valid),
    .res_kind  (res_kind),
    .res_accel (res_accel),
    .res_rate  (res_rate),
    .res_angle (res_angle)
  );

  assign out_frame_kind = res_kind;
  assign out_accel_x    = res_accel[0];
  assign out_accel_y    = res_accel[1];
  assign out_accel_z    = res_accel[2];
  assign out_rate_x     = res_rate[0];
  assign out_rate_y     = res_rate[1];
  assign out_rate_z     = res_rate[2];
  assign out_roll_deg   = res_angle[0];
  assign out_pitch_deg  = res_angle[1];
  assign out_yaw_deg    = res_angle[2];

  // A completed frame only appears after a byte transfer.
  a_frame_from_byte : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ctl.valid) |-> $past(in_take))
    else $error("frame flagged without a byte transfer");

  // A new result only appears when the frame register handed one over.
  a_result_from_frame : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctl_take))
    else $error("result appeared without a completed frame");

  // Input stalls only while a finished frame is blocked behind a held result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (ctl.valid && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // A frame handed over is visible at the output in the next cycle.
  a_handover : assert property (@(posedge clk) disable iff (!rst_n)
    ctl_take |=> out_valid)
    else $error("handed-over frame lost");

endmodule
`default_nettype wire
